[hw/rtl/dsm_pkg.sv]
// ----------------------------------------------------------------------------
// dsm_pkg
// Shared codes, types and constants for the dot-star pattern matcher.
// ----------------------------------------------------------------------------
package dsm_pkg;

    localparam logic [1:0] ACT_CLEAR  = 2'd0;
    localparam logic [1:0] ACT_APPEND = 2'd1;
    localparam logic [1:0] ACT_TEXT   = 2'd2;
    localparam logic [1:0] ACT_END    = 2'd3;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
    localparam logic [1:0] ERR_MALFORMED = 2'd2;

    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] DOT_BYTE  = 8'h2E;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_TEXT  = 3'b010,
        S_REARM = 3'b100
    } t_state;

    typedef struct packed {
        logic       wr_en;
        logic       text_mode;
        logic [7:0] wr_sym;
        logic [7:0] text_sym;
    } t_cell_ctl;

endpackage

[hw/rtl/dot_star_regex_matcher.sv]
// ----------------------------------------------------------------------------
// dot_star_regex_matcher
// Whole-string matcher for '.' and '*' patterns, one cell per pattern byte.
// ----------------------------------------------------------------------------
// Any input transfer: the next one is not taken until the row has settled,
//   i.e. the work row stops changing; set row bits spread along chains
//   linked through star cells while it settles.
// Result is registered and appears in the cycle after the end-of-text transfer.
// Reset: empty pattern, flags clear, row holds only bit zero; no sweep.
module dot_star_regex_matcher #(
    parameter int MAX_PATTERN = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_action,
    input  logic [7:0] i_symbol,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_matched,
    output logic [1:0] o_error_code
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    dsm_pkg::t_state     r_state;
    logic [LEN_W-1:0]    r_len;
    logic                r_over;
    logic                r_mal;
    logic                r_last_star;
    logic [MAX_PATTERN:0] r_row;
    logic [MAX_PATTERN:0] r_work;
    logic [MAX_PATTERN:0] n_work;
    logic [MAX_PATTERN+1:0] work_ext;
    logic [7:0]          r_sym;
    logic                r_out_valid;
    logic                r_matched;
    logic [1:0]          r_err;
    logic [7:0]          cell_char [0:MAX_PATTERN-1];
    dsm_pkg::t_cell_ctl  ctl;
    logic                acc_in;
    logic                idle;
    logic                busy;
    logic                converged;
    logic                full;

    assign idle      = (r_state == dsm_pkg::S_IDLE);
    assign busy      = !idle;
    assign full      = (r_len == LEN_W'(MAX_PATTERN));
    assign o_in_stall = busy ||
                        ((i_action == dsm_pkg::ACT_END) && r_out_valid && i_out_stall);
    assign acc_in    = i_in_valid && !o_in_stall;
    assign converged = (n_work == r_work);

    assign ctl.wr_en     = acc_in && (i_action == dsm_pkg::ACT_APPEND) && !full;
    assign ctl.text_mode = (r_state == dsm_pkg::S_TEXT);
    assign ctl.wr_sym    = i_symbol;
    assign ctl.text_sym  = r_sym;

    assign cell_char[0] = 8'h00;
    assign work_ext     = {r_work, 1'b0};
    assign n_work[0]    = !ctl.text_mode;

    for (genvar g = 1; g <= MAX_PATTERN; g++) begin : g_cell
        if (g < MAX_PATTERN) begin : g_mid
            dsm_cell #(
                .IDX   (g),
                .LEN_W (LEN_W)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctl       (ctl),
                .i_len       (r_len),
                .i_elem      (cell_char[g-1]),
                .i_prev_lo   (r_row[g-1]),
                .i_prev_here (r_row[g]),
                .i_back2     (work_ext[g-1]),
                .o_char      (cell_char[g]),
                .o_next      (n_work[g])
            );
        end else begin : g_last
            dsm_cell #(
                .IDX   (g),
                .LEN_W (LEN_W)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctl       (ctl),
                .i_len       (r_len),
                .i_elem      (cell_char[g-1]),
                .i_prev_lo   (r_row[g-1]),
                .i_prev_here (r_row[g]),
                .i_back2     (work_ext[g-1]),
                .o_char      (),
                .o_next      (n_work[g])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dsm_pkg::S_IDLE;
            r_len       <= '0;
            r_over      <= 1'b0;
            r_mal       <= 1'b0;
            r_last_star <= 1'b0;
            r_row       <= (MAX_PATTERN + 1)'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (acc_in && (i_action == dsm_pkg::ACT_END)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state) inside
                dsm_pkg::S_IDLE: begin
                    if (acc_in) begin
                        case (i_action)
                            dsm_pkg::ACT_CLEAR: begin
                                r_len       <= '0;
                                r_over      <= 1'b0;
                                r_mal       <= 1'b0;
                                r_last_star <= 1'b0;
                                r_state     <= dsm_pkg::S_REARM;
                            end
                            dsm_pkg::ACT_APPEND: begin
                                if (full) begin
                                    r_over <= 1'b1;
                                end else begin
                                    r_len       <= r_len + 1'b1;
                                    r_last_star <= (i_symbol == dsm_pkg::STAR_BYTE);
                                    if ((i_symbol == dsm_pkg::STAR_BYTE) &&
                                        ((r_len == '0) || r_last_star)) begin
                                        r_mal <= 1'b1;
                                    end
                                end
                                r_state <= dsm_pkg::S_REARM;
                            end
                            dsm_pkg::ACT_TEXT: begin
                                r_state <= dsm_pkg::S_TEXT;
                            end
                            default: begin
                                r_state <= dsm_pkg::S_REARM;
                            end
                        endcase
                    end
                end
                dsm_pkg::S_TEXT, dsm_pkg::S_REARM: begin
                    if (converged) begin
                        r_row   <= r_work;
                        r_state <= dsm_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= dsm_pkg::S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (idle) begin
            r_work <= '0;
        end else begin
            r_work <= n_work;
        end
        if (acc_in && (i_action == dsm_pkg::ACT_TEXT)) begin
            r_sym <= i_symbol;
        end
        if (acc_in && (i_action == dsm_pkg::ACT_END)) begin
            r_matched <= !r_mal && r_row[r_len];
            r_err     <= r_mal ? dsm_pkg::ERR_MALFORMED :
                         (r_over ? dsm_pkg::ERR_OVERFLOW : dsm_pkg::ERR_NONE);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_matched    = r_matched;
    assign o_error_code = r_err;

    a_end_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_in && (i_action == dsm_pkg::ACT_END)
        |=> o_out_valid && (r_state == dsm_pkg::S_REARM))
        else $error("end of text did not post a result and rearm");

    a_work_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy && $past(busy) |-> (($past(r_work) & ~r_work) == '0))
        else $error("match row bit dropped during settling");

    a_malformed_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_error_code == dsm_pkg::ERR_MALFORMED) |-> !o_matched)
        else $error("malformed pattern reported a match");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(MAX_PATTERN))
        else $error("pattern length beyond store");

endmodule

[hw/rtl/dsm_cell.sv]
// ----------------------------------------------------------------------------
// dsm_cell
// One pattern position: holds its byte and computes its match bit.
// ----------------------------------------------------------------------------
module dsm_cell #(
    parameter int IDX   = 1,
    parameter int LEN_W = 6
) (
    input  logic               i_clk,
    input  dsm_pkg::t_cell_ctl i_ctl,
    input  logic [LEN_W-1:0]   i_len,
    input  logic [7:0]         i_elem,
    input  logic               i_prev_lo,
    input  logic               i_prev_here,
    input  logic               i_back2,
    output logic [7:0]         o_char,
    output logic               o_next
);

    logic [7:0] r_char;
    logic       active;
    logic       is_star;
    logic       star_ok;
    logic       elem_match;
    logic       lit_match;
    logic       base;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en && (i_len == LEN_W'(IDX - 1))) begin
            r_char <= i_ctl.wr_sym;
        end
    end

    assign active     = (LEN_W'(IDX) <= i_len);
    assign is_star    = (r_char == dsm_pkg::STAR_BYTE);
    assign star_ok    = (IDX >= 2) && (i_elem != dsm_pkg::STAR_BYTE);
    assign elem_match = (i_elem == i_ctl.text_sym) || (i_elem == dsm_pkg::DOT_BYTE);
    assign lit_match  = (r_char == i_ctl.text_sym) || (r_char == dsm_pkg::DOT_BYTE);

    always_comb begin
        if (!i_ctl.text_mode) begin
            base = 1'b0;
        end else if (is_star) begin
            base = star_ok & elem_match & (i_prev_lo | i_prev_here);
        end else begin
            base = lit_match & i_prev_lo;
        end
    end

    assign o_next = active & (base | (is_star & star_ok & i_back2));
    assign o_char = r_char;

endmodule
